>>> sv/mpl_pkg.sv
`default_nettype none

package mpl_pkg;

  // operation codes of an input item
  localparam logic [1:0] OpQuery   = 2'd0;
  localparam logic [1:0] OpHostWr  = 2'd1;
  localparam logic [1:0] OpNetWr   = 2'd2;
  localparam logic [1:0] OpNop     = 2'd3;

  // decision codes of a result
  localparam logic [1:0] DecNone   = 2'd0;
  localparam logic [1:0] DecIgnore = 2'd1;
  localparam logic [1:0] DecSet    = 2'd2;
  localparam logic [1:0] DecRand   = 2'd3;

  // entry action codes
  localparam logic [1:0] ActIgnore = 2'd0;
  localparam logic [1:0] ActSet    = 2'd1;
  localparam logic [1:0] ActRand   = 2'd2;
  localparam logic [1:0] ActRsvd   = 2'd3;

  // requester condition codes
  localparam logic [1:0] CondNone   = 2'd0;
  localparam logic [1:0] CondDiffer = 2'd1;
  localparam logic [1:0] CondEqual  = 2'd2;
  localparam logic [1:0] CondRsvd   = 2'd3;

  // configuration register indexes
  localparam logic RegHostCount = 1'b0;
  localparam logic RegNetCount  = 1'b1;

  localparam int unsigned CfgAddrW = 3;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [47:0] cond_mac;
    logic [3:0]  flags;
  } host_entry_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] mask;
    logic [47:0] mac;
    logic [47:0] cond_mac;
    logic [3:0]  flags;
  } net_entry_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  decision;
    logic [47:0] reply_mac;
    logic        poison_valid;
    logic [47:0] decoy_mac;
  } eval_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic cnt_clr;
    logic cnt_inc;
    logic rd_host;
    logic rd_net;
    logic sel_net;
    logic res_load;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic host_end;
    logic net_end;
    logic ip_match;
    logic dec_hit;
    logic out_free;
  } sts_t;

  // condition rules for one entry whose address matches
  function automatic eval_t eval_entry(logic [3:0] flags, logic [47:0] emac,
                                       logic [47:0] ecmac, logic has_mac,
                                       logic [47:0] qmac);
    eval_t      r;
    logic [1:0] cond;
    logic [1:0] act;
    logic       eq;
    r    = '0;
    cond = (flags[3:2] == CondRsvd) ? CondNone : flags[3:2];
    act  = (flags[1:0] == ActRsvd) ? DecIgnore : flags[1:0] + 2'd1;
    eq   = (ecmac == qmac);
    if (cond == CondNone) begin
      r.hit       = 1'b1;
      r.decision  = act;
      r.reply_mac = (act == DecSet) ? emac : '0;
    end else if (!has_mac) begin
      r.hit      = 1'b1;
      r.decision = DecIgnore;
    end else if ((eq && cond == CondEqual) || (!eq && cond == CondDiffer)) begin
      r.hit       = 1'b1;
      r.decision  = act;
      r.reply_mac = (act == DecSet) ? emac : '0;
      if (cond == CondDiffer) begin
        r.poison_valid = 1'b1;
        r.decoy_mac    = ecmac;
      end
    end else if (eq && act != DecIgnore) begin
      r.hit      = 1'b1;
      r.decision = DecIgnore;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/mpl_if.sv
`default_nettype none

// request channel
interface mpl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [5:0]  entry_index;
  logic [31:0] ip_addr;
  logic [31:0] net_mask;
  logic [1:0]  entry_action;
  logic [47:0] mac_addr;
  logic        query_has_mac;
  logic [1:0]  cond_mode;
  logic [47:0] cond_mac;

  modport source (output valid, opcode, entry_index, ip_addr, net_mask, entry_action,
                  mac_addr, query_has_mac, cond_mode, cond_mac, input ready);
  modport sink (input valid, opcode, entry_index, ip_addr, net_mask, entry_action,
                mac_addr, query_has_mac, cond_mode, cond_mac, output ready);
endinterface

// result channel
interface mpl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  decision;
  logic [47:0] reply_mac;
  logic        poison_valid;
  logic [47:0] decoy_mac;

  modport source (output valid, decision, reply_mac, poison_valid, decoy_mac,
                  input ready);
  modport sink (input valid, decision, reply_mac, poison_valid, decoy_mac,
                output ready);
endinterface

`default_nettype wire

>>> sv/mpl_ram.sv
`default_nettype none

module mpl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/mpl_dp.sv
`default_nettype none

module mpl_dp #(
  parameter int unsigned HostEntries = 64,
  parameter int unsigned NetEntries  = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  mpl_in_if.sink             in_m,
  mpl_out_if.source          out_o,
  input  wire logic          in_ready_i,
  input  wire logic [6:0]    host_count_i,
  input  wire logic [5:0]    net_count_i,
  input  wire mpl_pkg::cmd_t cmd_i,
  output mpl_pkg::sts_t      sts_o
);

  localparam int unsigned HostAw = (HostEntries > 1) ? $clog2(HostEntries) : 1;
  localparam int unsigned NetAw  = (NetEntries > 1) ? $clog2(NetEntries) : 1;
  localparam int unsigned MaxE   = (HostEntries > NetEntries) ? HostEntries : NetEntries;
  localparam int unsigned CntW   = $clog2(MaxE + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     qip_q;
  logic [47:0]     qmac_q;
  logic            qhas_q;
  logic            qry_q;
  mpl_pkg::eval_t  res_q, res_d;
  mpl_pkg::eval_t  outr_q;
  logic            out_valid_q;

  mpl_pkg::host_entry_t hwr, hrd;
  mpl_pkg::net_entry_t  nwr, nrd;
  logic                 hwe, nwe;
  mpl_pkg::eval_t       ev;

  // request ready comes from the controller
  assign in_m.ready = in_ready_i;

  // table writes on an accepted write item
  always_comb begin
    hwr.ip       = in_m.ip_addr;
    hwr.mac      = in_m.mac_addr;
    hwr.cond_mac = in_m.cond_mac;
    hwr.flags    = {in_m.cond_mode, in_m.entry_action};
    nwr.ip       = in_m.ip_addr & in_m.net_mask;
    nwr.mask     = in_m.net_mask;
    nwr.mac      = in_m.mac_addr;
    nwr.cond_mac = in_m.cond_mac;
    nwr.flags    = {in_m.cond_mode, in_m.entry_action};
    hwe = cmd_i.accept && (in_m.opcode == mpl_pkg::OpHostWr)
          && (32'(in_m.entry_index) < HostEntries);
    nwe = cmd_i.accept && (in_m.opcode == mpl_pkg::OpNetWr)
          && (32'(in_m.entry_index) < NetEntries);
  end

  mpl_ram #(.Width($bits(mpl_pkg::host_entry_t)), .Depth(HostEntries)) u_host_ram (
    .clk_i   (clk_i),
    .we_i    (hwe),
    .waddr_i (HostAw'(in_m.entry_index)),
    .wdata_i (hwr),
    .re_i    (cmd_i.rd_host),
    .raddr_i (cnt_q[HostAw-1:0]),
    .rdata_o (hrd)
  );

  mpl_ram #(.Width($bits(mpl_pkg::net_entry_t)), .Depth(NetEntries)) u_net_ram (
    .clk_i   (clk_i),
    .we_i    (nwe),
    .waddr_i (NetAw'(in_m.entry_index)),
    .wdata_i (nwr),
    .re_i    (cmd_i.rd_net),
    .raddr_i (cnt_q[NetAw-1:0]),
    .rdata_o (nrd)
  );

  // entry check on the data read last cycle
  always_comb begin
    if (cmd_i.sel_net) begin
      ev = mpl_pkg::eval_entry(nrd.flags, nrd.mac, nrd.cond_mac, qhas_q, qmac_q);
      sts_o.ip_match = ((qip_q & nrd.mask) == nrd.ip);
    end else begin
      ev = mpl_pkg::eval_entry(hrd.flags, hrd.mac, hrd.cond_mac, qhas_q, qmac_q);
      sts_o.ip_match = (qip_q == hrd.ip);
    end
    sts_o.dec_hit  = ev.hit;
    sts_o.is_query = qry_q;
    sts_o.host_end = (32'(cnt_q) >= 32'(host_count_i)) || (32'(cnt_q) >= HostEntries);
    sts_o.net_end  = (32'(cnt_q) >= 32'(net_count_i)) || (32'(cnt_q) >= NetEntries);
    sts_o.out_free = !out_valid_q || out_o.ready;
  end

  // scan counter and result
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CntW'(1);
    end
    res_d = res_q;
    if (cmd_i.accept) begin
      res_d = '0;
    end else if (cmd_i.res_load) begin
      res_d = ev;
    end
  end

  // query and result registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    res_q <= res_d;
    if (cmd_i.accept) begin
      qip_q  <= in_m.ip_addr;
      qmac_q <= in_m.mac_addr;
      qhas_q <= in_m.query_has_mac;
      qry_q  <= (in_m.opcode == mpl_pkg::OpQuery);
    end
    if (cmd_i.out_load) begin
      outr_q <= res_q;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.decision     = outr_q.decision;
  assign out_o.reply_mac    = outr_q.reply_mac;
  assign out_o.poison_valid = outr_q.poison_valid;
  assign out_o.decoy_mac    = outr_q.decoy_mac;

endmodule

`default_nettype wire

>>> sv/mpl_ctrl.sv
`default_nettype none

module mpl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mpl_pkg::sts_t sts_i,
  output mpl_pkg::cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StHRd  = 6'b000010,
    StHChk = 6'b000100,
    StNRd  = 6'b001000,
    StNChk = 6'b010000,
    StFin  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // sequencer over host scan, then network scan
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = StHRd;
        end
      end
      StHRd: begin
        if (!sts_i.is_query) begin
          state_d = StFin;
        end else if (sts_i.host_end) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = StNRd;
        end else begin
          cmd_o.rd_host = 1'b1;
          state_d       = StHChk;
        end
      end
      StHChk: begin
        if (sts_i.ip_match) begin
          if (sts_i.dec_hit) begin
            cmd_o.res_load = 1'b1;
            state_d        = StFin;
          end else begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = StNRd;
          end
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = StHRd;
        end
      end
      StNRd: begin
        cmd_o.sel_net = 1'b1;
        if (sts_i.net_end) begin
          state_d = StFin;
        end else begin
          cmd_o.rd_net = 1'b1;
          state_d      = StNChk;
        end
      end
      StNChk: begin
        cmd_o.sel_net = 1'b1;
        if (sts_i.ip_match && sts_i.dec_hit) begin
          cmd_o.res_load = 1'b1;
          state_d        = StFin;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = StNRd;
        end
      end
      StFin: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/ip_mac_policy_lookup.sv
// IP to MAC policy lookup. Software loads a host table of exact addresses and a
// prioritized network table of masked addresses through the request channel
// (opcode 1 and 2), and sets the entry counts in two APB registers (host_count
// at 0x0, net_count at 0x4). A query (opcode 0) scans the host table for the
// first equal address, then the network table in order, applying the requester
// MAC condition of each entry, and returns one result; writes return an all-zero
// result. One item is worked on at a time: the scan reads one table entry at a
// time from the entry memory, issuing the address in a read state and checking
// the registered data in a check state. A finished result sits in an output
// register, so the next item may be taken while it waits.
`default_nettype none

module ip_mac_policy_lookup #(
  parameter int unsigned HOST_ENTRIES = 64,
  parameter int unsigned NET_ENTRIES  = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mpl_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  mpl_in_if.sink                             in_i,
  mpl_out_if.source                          out_o
);

  logic [6:0]    host_count_q;
  logic [5:0]    net_count_q;
  logic          cfg_we;
  logic          in_ready;
  mpl_pkg::cmd_t cmd;
  mpl_pkg::sts_t sts;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_count_q <= '0;
      net_count_q  <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        mpl_pkg::RegHostCount: host_count_q <= pwdata[6:0];
        mpl_pkg::RegNetCount:  net_count_q  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mpl_pkg::RegHostCount: prdata = {25'd0, host_count_q};
      mpl_pkg::RegNetCount:  prdata = {26'd0, net_count_q};
      default:               prdata = '0;
    endcase
  end

  mpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpl_dp #(
    .HostEntries (HOST_ENTRIES),
    .NetEntries  (NET_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_m         (in_i),
    .out_o        (out_o),
    .in_ready_i   (in_ready),
    .host_count_i (host_count_q),
    .net_count_i  (net_count_q),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request taken while an item is in flight");

  // result register loaded only when free or being drained
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten");

  // result register loads only at the end of an item
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> in_i.ready)
    else $error("controller not idle after result load");

  // host count register takes the written value
  a_cfg_host: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we && !paddr[2] |=> host_count_q == $past(pwdata[6:0]))
    else $error("host count write lost");

endmodule

`default_nettype wire

>>> tb/sv/tb_ip_mac_policy_lookup.sv
`timescale 1ns / 100ps

module tb_ip_mac_policy_lookup;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  idx;
    logic [31:0] ip;
    logic [31:0] mask;
    logic [1:0]  action;
    logic [47:0] mac;
    logic        has_mac;
    logic [1:0]  cond;
    logic [47:0] cond_mac;
  } req_t;

  typedef struct {
    logic [1:0]  decision;
    logic [47:0] reply_mac;
    logic        poison_valid;
    logic [47:0] decoy_mac;
  } verdict_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [mpl_pkg::CfgAddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  mpl_in_if  req_if ();
  mpl_out_if rsp_if ();

  ip_mac_policy_lookup i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (req_if),
    .out_o   (rsp_if)
  );

  // shadow tables and counts
  logic [31:0] sh_host_ip [64];
  logic [47:0] sh_host_mac [64];
  logic [47:0] sh_host_cmac [64];
  logic [3:0]  sh_host_flags [64];
  logic [31:0] sh_net_ip [32];
  logic [31:0] sh_net_mask [32];
  logic [47:0] sh_net_mac [32];
  logic [47:0] sh_net_cmac [32];
  logic [3:0]  sh_net_flags [32];
  int unsigned sh_host_cnt;
  int unsigned sh_net_cnt;

  req_t     pend_items [$];
  verdict_t want_verdicts [$];
  req_t     on_bus;
  int unsigned n_accepted;
  int unsigned n_errors;
  logic     hold_rx;
  bit       hold_done;

  logic [47:0] mac_pool [4] = '{48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF,
                                48'h0200_1122_3344, 48'hA5A5_5A5A_0F0F};

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // condition rules for one address-matching entry; returns 1 on a decision
  function automatic bit rule_check(logic [3:0] fl, logic [47:0] emac, logic [47:0] ecmac,
                                    logic has, logic [47:0] qmac, ref verdict_t v);
    logic [1:0] cmode;
    logic [1:0] dec;
    logic       same;
    cmode = (fl[3:2] == mpl_pkg::CondRsvd) ? mpl_pkg::CondNone : fl[3:2];
    dec   = (fl[1:0] == mpl_pkg::ActRsvd) ? mpl_pkg::DecIgnore : fl[1:0] + 2'd1;
    same  = (ecmac == qmac);
    if (cmode != mpl_pkg::CondNone && !has) begin
      v.decision = mpl_pkg::DecIgnore;
      return 1'b1;
    end
    if (cmode == mpl_pkg::CondNone || (same && cmode == mpl_pkg::CondEqual) ||
        (!same && cmode == mpl_pkg::CondDiffer)) begin
      v.decision  = dec;
      v.reply_mac = (dec == mpl_pkg::DecSet) ? emac : '0;
      if (cmode == mpl_pkg::CondDiffer) begin
        v.poison_valid = 1'b1;
        v.decoy_mac    = ecmac;
      end
      return 1'b1;
    end
    if (same && dec != mpl_pkg::DecIgnore) begin
      v.decision = mpl_pkg::DecIgnore;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one item to the shadow tables and work out its verdict
  function automatic verdict_t policy_apply(req_t q);
    verdict_t v;
    int unsigned n;
    v = '{mpl_pkg::DecNone, '0, 1'b0, '0};
    if (q.op == mpl_pkg::OpHostWr) begin
      sh_host_ip[q.idx]    = q.ip;
      sh_host_mac[q.idx]   = q.mac;
      sh_host_cmac[q.idx]  = q.cond_mac;
      sh_host_flags[q.idx] = {q.cond, q.action};
    end else if (q.op == mpl_pkg::OpNetWr) begin
      if (q.idx < 32) begin
        sh_net_ip[q.idx]    = q.ip & q.mask;
        sh_net_mask[q.idx]  = q.mask;
        sh_net_mac[q.idx]   = q.mac;
        sh_net_cmac[q.idx]  = q.cond_mac;
        sh_net_flags[q.idx] = {q.cond, q.action};
      end
    end else if (q.op == mpl_pkg::OpQuery) begin
      n = (sh_host_cnt > 64) ? 64 : sh_host_cnt;
      for (int i = 0; i < n; i++) begin
        if (sh_host_ip[i] == q.ip) begin
          void'(rule_check(sh_host_flags[i], sh_host_mac[i], sh_host_cmac[i],
                           q.has_mac, q.mac, v));
          break;
        end
      end
      if (v.decision == mpl_pkg::DecNone) begin
        n = (sh_net_cnt > 32) ? 32 : sh_net_cnt;
        for (int i = 0; i < n; i++) begin
          if ((q.ip & sh_net_mask[i]) == sh_net_ip[i] &&
              rule_check(sh_net_flags[i], sh_net_mac[i], sh_net_cmac[i],
                         q.has_mac, q.mac, v))
            break;
        end
      end
    end
    return v;
  endfunction

  // no idling on either side for a stretch of transfers
  function automatic bit calm_window();
    return n_accepted >= 300 && n_accepted < 500;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      n_accepted <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        want_verdicts.push_back(policy_apply(on_bus));
        n_accepted <= n_accepted + 1;
      end
      if (pend_items.size() != 0 && (calm_window() || $urandom_range(99) >= 17)) begin
        on_bus = pend_items.pop_front();
        req_if.valid         <= 1'b1;
        req_if.opcode        <= on_bus.op;
        req_if.entry_index   <= on_bus.idx;
        req_if.ip_addr       <= on_bus.ip;
        req_if.net_mask      <= on_bus.mask;
        req_if.entry_action  <= on_bus.action;
        req_if.mac_addr      <= on_bus.mac;
        req_if.query_has_mac <= on_bus.has_mac;
        req_if.cond_mode     <= on_bus.cond;
        req_if.cond_mac      <= on_bus.cond_mac;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_rx <= 1'b0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= 700) begin
      hold_done <= 1'b1;
      hold_rx <= 1'b1;
      for (int c = 0; c < 400; c++) @(posedge clk_i);
      hold_rx <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t w;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      n_errors <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (want_verdicts.size() == 0) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10)
            $display("unexpected result transfer: got dec %0d mac %h pv %0d dmac %h",
                     rsp_if.decision, rsp_if.reply_mac, rsp_if.poison_valid,
                     rsp_if.decoy_mac);
        end else begin
          w = want_verdicts.pop_front();
          if (rsp_if.decision !== w.decision || rsp_if.reply_mac !== w.reply_mac ||
              rsp_if.poison_valid !== w.poison_valid ||
              rsp_if.decoy_mac !== w.decoy_mac) begin
            n_errors <= n_errors + 1;
            if (n_errors < 10)
              $display("mismatch: exp dec %0d mac %h pv %0d dmac %h, got dec %0d mac %h pv %0d dmac %h",
                       w.decision, w.reply_mac, w.poison_valid, w.decoy_mac,
                       rsp_if.decision, rsp_if.reply_mac, rsp_if.poison_valid,
                       rsp_if.decoy_mac);
          end
        end
      end
      rsp_if.ready <= !hold_rx && (calm_window() || $urandom_range(99) >= 17);
    end
  end

  task automatic cfg_write(logic reg_sel, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == mpl_pkg::RegHostCount) sh_host_cnt = value[6:0];
    else sh_net_cnt = value[5:0];
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pend_items.size() != 0 || req_if.valid || want_verdicts.size() != 0);
    repeat (5) @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[47:0];
  endfunction

  function automatic logic [31:0] pool_ip();
    return ($urandom_range(99) < 60) ? 32'h0A00_0000 + $urandom_range(15) : $urandom;
  endfunction

  function automatic req_t mk_entry(logic [1:0] op, logic [5:0] slot);
    req_t r;
    int unsigned plen;
    plen       = $urandom_range(32);
    r.op       = op;
    r.idx      = slot;
    r.ip       = pool_ip();
    r.mask     = (plen == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - plen);
    r.action   = 2'($urandom_range(3));
    r.mac      = rand_mac();
    r.has_mac  = 1'($urandom_range(1));
    r.cond     = 2'($urandom_range(3));
    r.cond_mac = ($urandom_range(99) < 80) ? mac_pool[$urandom_range(3)] : rand_mac();
    return r;
  endfunction

  function automatic req_t mk_query();
    req_t r;
    int unsigned k;
    int unsigned pick;
    r = mk_entry(mpl_pkg::OpQuery, 6'($urandom_range(63)));
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.ip = sh_host_ip[$urandom_range(63)];
    end else if (pick < 70) begin
      k = $urandom_range(31);
      r.ip = sh_net_ip[k] | ($urandom & ~sh_net_mask[k]);
    end
    r.mac = ($urandom_range(99) < 70) ? mac_pool[$urandom_range(3)] : rand_mac();
    r.has_mac = ($urandom_range(99) < 80);
    return r;
  endfunction

  function automatic req_t mk_fixed(logic [1:0] op, logic [5:0] slot, logic [31:0] ip,
                                    logic [31:0] mask, logic [1:0] act, logic [47:0] mac,
                                    logic has, logic [1:0] cmode, logic [47:0] cmac);
    req_t r;
    r = '{op, slot, ip, mask, act, mac, has, cmode, cmac};
    return r;
  endfunction

  // stimulus
  initial begin
    int unsigned r;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sh_host_cnt = 0;
    sh_net_cnt = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty tables: no entry
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0A00_0001, 0, 0, 0, 1'b0, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  mpl_pkg::ActRsvd, 48'hFFFF_FFFF_FFFF, 1'b1,
                                  mpl_pkg::CondRsvd, 48'hFFFF_FFFF_FFFF));
    // directed entries
    pend_items.push_back(mk_fixed(mpl_pkg::OpHostWr, 0, 32'h0A00_0001, 0, mpl_pkg::ActSet,
                                  48'h0011_2233_4455, 0, mpl_pkg::CondNone, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpHostWr, 1, 32'h0A00_0002, 0, mpl_pkg::ActRand,
                                  0, 0, mpl_pkg::CondDiffer, mac_pool[2]));
    pend_items.push_back(mk_fixed(mpl_pkg::OpHostWr, 2, 32'h0A00_0003, 0, mpl_pkg::ActRsvd,
                                  0, 0, mpl_pkg::CondEqual, mac_pool[3]));
    pend_items.push_back(mk_fixed(mpl_pkg::OpHostWr, 3, 32'h0000_0000, 0,
                                  mpl_pkg::ActIgnore, 48'hFFFF_FFFF_FFFF, 0,
                                  mpl_pkg::CondRsvd, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpNetWr, 0, 32'h0AFF_FFFF, 32'hFF00_0000,
                                  mpl_pkg::ActIgnore, 0, 0, mpl_pkg::CondDiffer,
                                  mac_pool[2]));
    pend_items.push_back(mk_fixed(mpl_pkg::OpNetWr, 1, 32'h0A00_0000, 32'hFF00_0000,
                                  mpl_pkg::ActSet, 48'h0A0B_0C0D_0E0F, 0,
                                  mpl_pkg::CondEqual, mac_pool[3]));
    pend_items.push_back(mk_fixed(mpl_pkg::OpNetWr, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  mpl_pkg::ActRand, 0, 0, mpl_pkg::CondNone, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpNetWr, 3, 32'h1234_5678, 32'h0,
                                  mpl_pkg::ActSet, 48'hFFFF_FFFF_FFFF, 0,
                                  mpl_pkg::CondNone, 0));
    // out of range network slot and the unused opcode
    pend_items.push_back(mk_fixed(mpl_pkg::OpNetWr, 40, 32'hFFFF_FFFF, 0, mpl_pkg::ActSet,
                                  48'hFFFF_FFFF_FFFF, 1, mpl_pkg::CondEqual,
                                  48'hFFFF_FFFF_FFFF));
    pend_items.push_back(mk_fixed(mpl_pkg::OpNop, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  mpl_pkg::ActRsvd, 48'hFFFF_FFFF_FFFF, 1,
                                  mpl_pkg::CondRsvd, 48'hFFFF_FFFF_FFFF));
    drain();
    cfg_write(mpl_pkg::RegHostCount, 4);
    cfg_write(mpl_pkg::RegNetCount, 4);

    // host hits: plain, must-differ match, equal-ignore, no requester mac
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0A00_0001, 0, 0, 0, 0, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0A00_0002, 0, 0, mac_pool[3],
                                  1, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0A00_0002, 0, 0, mac_pool[2],
                                  1, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0A00_0002, 0, 0, mac_pool[2],
                                  0, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0A00_0003, 0, 0, mac_pool[3],
                                  1, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0A00_0003, 0, 0, mac_pool[2],
                                  1, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0000_0000, 0, 0, 0, 1, 0, 0));
    // network: the first matching entry wins; skipped entries fall through to the catch-all
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0A12_3456, 0, 0, mac_pool[2],
                                  1, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h0A12_3456, 0, 0, mac_pool[1],
                                  1, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    pend_items.push_back(mk_fixed(mpl_pkg::OpQuery, 0, 32'h7777_0000, 0, 0, 0, 0, 0, 0));
    drain();

    // fill every slot, with some ignored items mixed in
    for (int i = 0; i < 64; i++) pend_items.push_back(mk_entry(mpl_pkg::OpHostWr, 6'(i)));
    for (int i = 0; i < 32; i++) begin
      pend_items.push_back(mk_entry(mpl_pkg::OpNetWr, 6'(i)));
      if ($urandom_range(3) == 0)
        pend_items.push_back(mk_entry(mpl_pkg::OpNetWr, 6'(32 + $urandom_range(31))));
      if ($urandom_range(7) == 0)
        pend_items.push_back(mk_entry(mpl_pkg::OpNop, 6'($urandom_range(63))));
    end
    drain();

    // random phases over several count settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          cfg_write(mpl_pkg::RegHostCount, 127);
          cfg_write(mpl_pkg::RegNetCount, 63);
        end
        1: begin
          cfg_write(mpl_pkg::RegHostCount, 0);
          cfg_write(mpl_pkg::RegNetCount, 0);
        end
        2: begin
          cfg_write(mpl_pkg::RegHostCount, 64);
          cfg_write(mpl_pkg::RegNetCount, 32);
        end
        3: begin
          cfg_write(mpl_pkg::RegHostCount, 1);
          cfg_write(mpl_pkg::RegNetCount, 1);
        end
        5: begin
          cfg_write(mpl_pkg::RegHostCount, 0);
          cfg_write(mpl_pkg::RegNetCount, 32);
        end
        6: begin
          cfg_write(mpl_pkg::RegHostCount, 64);
          cfg_write(mpl_pkg::RegNetCount, 0);
        end
        default: begin
          cfg_write(mpl_pkg::RegHostCount, $urandom_range(127));
          cfg_write(mpl_pkg::RegNetCount, $urandom_range(63));
        end
      endcase
      for (int k = 0; k < 150; k++) begin
        r = $urandom_range(99);
        if (r < 70)
          pend_items.push_back(mk_query());
        else if (r < 82)
          pend_items.push_back(mk_entry(mpl_pkg::OpHostWr, 6'($urandom_range(63))));
        else if (r < 95)
          pend_items.push_back(mk_entry(mpl_pkg::OpNetWr, 6'($urandom_range(63))));
        else
          pend_items.push_back(mk_entry(mpl_pkg::OpNop, 6'($urandom_range(63))));
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (n_errors == 0 && want_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
sv/mpl_pkg.sv
sv/mpl_if.sv
sv/mpl_ram.sv
sv/mpl_dp.sv
sv/mpl_ctrl.sv
sv/ip_mac_policy_lookup.sv
tb/sv/tb_ip_mac_policy_lookup.sv
